>>> hdl/sha512_pkg.sv
`timescale 1ns / 1ps
// sha512_pkg: types, constants and round functions for sha512_stream_hash
// no dependencies

package sha512_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_BYTES,
      ST_PAD80,
      ST_PADZ,
      ST_LEN_HI,
      ST_LEN_LO,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   localparam int unsigned WordBits   = 64;
   localparam int unsigned Rounds     = 80;
   localparam int unsigned MaxBytes   = 8;
   localparam logic [7:0]  PadByte    = 8'h80;
   localparam logic [3:0]  LenWordIdx = 4'd14;

   localparam logic [63:0] InitHash [0:7] = '{
      64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
      64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
   };

   localparam logic [63:0] RoundK [0:79] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] big_sigma0(input logic [63:0] x);
      big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic logic [63:0] big_sigma1(input logic [63:0] x);
      big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic logic [63:0] small_sigma0(input logic [63:0] x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic logic [63:0] small_sigma1(input logic [63:0] x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

>>> hdl/sha512_stream_hash.sv
`timescale 1ns / 1ps
// sha512_stream_hash: streaming SHA-512 with byte loader, one round unit and digest output
// depends on sha512_pkg
//
// Usage: req_ beats carry up to eight message bytes, big-endian in req_data_word, with
// req_byte_count valid bytes (above eight counts as eight) and req_end_of_message.
// req_ready is high only while the block is idle; a beat is taken when req_valid and
// req_ready are both high.
// Bytes enter the block buffer one per cycle, paused while a block is being compressed.
// Each full 128-byte block then runs 80 rounds through the single round
// unit and a fold of the working variables into the chaining value.
// A final beat adds padding (up to 128 pad bytes), two length words,
// a last compression and then eight rsp_ beats, word_index 0 to 7, last_word on 7.
// The digest stays on the rsp_ ports while rsp_ready is low; nothing else moves
// until all eight beats are taken. After the eighth the block returns to the
// standard initial hash value with an empty message.
// Reset (synchronous, active high) clears the message and loads the initial hash.

module sha512_stream_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_data_word,
   input  logic [3:0]  req_byte_count,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   sha512_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic [63:0] chain_ff [0:7];
   logic [63:0] chain_in [0:7];
   logic [63:0] var_ff   [0:7];
   logic [63:0] var_in   [0:7];
   logic [63:0] win_ff   [0:15];
   logic [63:0] win_in   [0:15];

   logic [63:0] acc_ff, acc_in;
   logic [63:0] data_ff, data_in;
   logic [3:0]  rem_ff, rem_in;
   logic        eom_ff, eom_in;
   logic [2:0]  pos_ff, pos_in;
   logic [3:0]  wcnt_ff, wcnt_in;
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;
   logic [63:0] total_ff, total_in;

   logic        put_en;
   logic [7:0]  put_byte;
   sha512_pkg::state_type put_next;
   logic        push_en;
   logic [63:0] push_word;
   logic [3:0]  cnt_sat;
   logic [63:0] t1, t2, w_new, acc_next;

   assign req_ready       = (state_ff == sha512_pkg::ST_IDLE);
   assign rsp_valid       = (state_ff == sha512_pkg::ST_EMIT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = (idx_ff == 3'd7);

   assign cnt_sat  = (req_byte_count > 4'(sha512_pkg::MaxBytes)) ?
                     4'(sha512_pkg::MaxBytes) : req_byte_count;
   assign acc_next = {acc_ff[55:0], put_byte};

   // round unit
   assign t1 = var_ff[7] + sha512_pkg::big_sigma1(var_ff[4])
             + ((var_ff[4] & var_ff[5]) ^ (~var_ff[4] & var_ff[6]))
             + sha512_pkg::RoundK[round_ff] + win_ff[0];
   assign t2 = sha512_pkg::big_sigma0(var_ff[0])
             + ((var_ff[0] & var_ff[1]) ^ (var_ff[0] & var_ff[2]) ^ (var_ff[1] & var_ff[2]));
   assign w_new = sha512_pkg::small_sigma1(win_ff[14]) + win_ff[9]
                + sha512_pkg::small_sigma0(win_ff[1]) + win_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha512_pkg::ST_IDLE;
         ret_ff   <= sha512_pkg::ST_IDLE;
         for (int i = 0; i < 8; i++) chain_ff[i] <= sha512_pkg::InitHash[i];
         rem_ff   <= '0;
         eom_ff   <= 1'b0;
         pos_ff   <= '0;
         wcnt_ff  <= '0;
         round_ff <= '0;
         idx_ff   <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         for (int i = 0; i < 8; i++) chain_ff[i] <= chain_in[i];
         rem_ff   <= rem_in;
         eom_ff   <= eom_in;
         pos_ff   <= pos_in;
         wcnt_ff  <= wcnt_in;
         round_ff <= round_in;
         idx_ff   <= idx_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 8; i++) var_ff[i] <= var_in[i];
      for (int i = 0; i < 16; i++) win_ff[i] <= win_in[i];
      acc_ff  <= acc_in;
      data_ff <= data_in;
   end

   always_comb begin
      state_in = state_ff;
      ret_in   = ret_ff;
      for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i];
      for (int i = 0; i < 8; i++) var_in[i] = var_ff[i];
      for (int i = 0; i < 16; i++) win_in[i] = win_ff[i];
      acc_in   = acc_ff;
      data_in  = data_ff;
      rem_in   = rem_ff;
      eom_in   = eom_ff;
      pos_in   = pos_ff;
      wcnt_in  = wcnt_ff;
      round_in = round_ff;
      idx_in   = idx_ff;
      total_in = total_ff;
      put_en    = 1'b0;
      put_byte  = '0;
      put_next  = state_ff;
      push_en   = 1'b0;
      push_word = acc_next;

      unique case (state_ff)
         sha512_pkg::ST_IDLE: begin
            if (req_valid) begin
               data_in  = req_data_word;
               rem_in   = cnt_sat;
               eom_in   = req_end_of_message;
               total_in = total_ff + 64'(cnt_sat);
               if (cnt_sat != 4'd0) begin
                  state_in = sha512_pkg::ST_BYTES;
               end else if (req_end_of_message) begin
                  state_in = sha512_pkg::ST_PAD80;
               end
            end
         end
         sha512_pkg::ST_BYTES: begin
            put_en   = 1'b1;
            put_byte = data_ff[63:56];
            data_in  = data_ff << 8;
            rem_in   = rem_ff - 4'd1;
            if (rem_ff == 4'd1) begin
               put_next = eom_ff ? sha512_pkg::ST_PAD80 : sha512_pkg::ST_IDLE;
            end else begin
               put_next = sha512_pkg::ST_BYTES;
            end
         end
         sha512_pkg::ST_PAD80: begin
            put_en   = 1'b1;
            put_byte = sha512_pkg::PadByte;
            put_next = sha512_pkg::ST_PADZ;
         end
         sha512_pkg::ST_PADZ: begin
            if (wcnt_ff == sha512_pkg::LenWordIdx && pos_ff == 3'd0) begin
               state_in = sha512_pkg::ST_LEN_HI;
            end else begin
               put_en   = 1'b1;
               put_next = sha512_pkg::ST_PADZ;
            end
         end
         sha512_pkg::ST_LEN_HI: begin
            push_en   = 1'b1;
            push_word = {61'd0, total_ff[63:61]};
            wcnt_in   = wcnt_ff + 4'd1;
            state_in  = sha512_pkg::ST_LEN_LO;
         end
         sha512_pkg::ST_LEN_LO: begin
            push_en   = 1'b1;
            push_word = {total_ff[60:0], 3'd0};
            wcnt_in   = wcnt_ff + 4'd1;
            ret_in    = sha512_pkg::ST_EMIT;
            round_in  = '0;
            for (int i = 0; i < 8; i++) var_in[i] = chain_ff[i];
            state_in  = sha512_pkg::ST_ROUND;
         end
         sha512_pkg::ST_ROUND: begin
            for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
            win_in[15] = w_new;
            var_in[7] = var_ff[6];
            var_in[6] = var_ff[5];
            var_in[5] = var_ff[4];
            var_in[4] = var_ff[3] + t1;
            var_in[3] = var_ff[2];
            var_in[2] = var_ff[1];
            var_in[1] = var_ff[0];
            var_in[0] = t1 + t2;
            round_in  = round_ff + 7'd1;
            if (round_ff == 7'(sha512_pkg::Rounds - 1)) begin
               state_in = sha512_pkg::ST_FOLD;
            end
         end
         sha512_pkg::ST_FOLD: begin
            for (int i = 0; i < 8; i++) chain_in[i] = chain_ff[i] + var_ff[i];
            idx_in   = '0;
            state_in = ret_ff;
         end
         sha512_pkg::ST_EMIT: begin
            if (rsp_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) chain_in[i] = sha512_pkg::InitHash[i];
                  total_in = '0;
                  state_in = sha512_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha512_pkg::ST_IDLE;
      endcase

      // byte loader
      if (put_en) begin
         acc_in   = acc_next;
         pos_in   = pos_ff + 3'd1;
         state_in = put_next;
         if (pos_ff == 3'd7) begin
            push_en = 1'b1;
            wcnt_in = wcnt_ff + 4'd1;
            if (wcnt_ff == 4'd15) begin
               ret_in   = put_next;
               round_in = '0;
               for (int i = 0; i < 8; i++) var_in[i] = chain_ff[i];
               state_in = sha512_pkg::ST_ROUND;
            end
         end
      end

      if (push_en) begin
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i + 1];
         win_in[15] = push_word;
      end
   end

endmodule

>>> bench/sha512_stream_hash_tb.sv
`timescale 1ns / 1ps
// sha512_stream_hash_tb: self-checking bench for the streaming SHA-512 block
// holds its own SHA-512 predictor and a digest scoreboard class
// depends on sha512_pkg (hash constants) and the sha512_stream_hash RTL

class digest_board;
   logic [63:0] cv [0:7];
   logic [63:0] buf_w [0:15];
   int unsigned fill;
   logic [63:0] total;
   logic [63:0] want_word [$];
   logic [2:0]  want_idx [$];
   logic        want_last [$];
   int unsigned errors;
   int unsigned digests;
   int unsigned beats_in;

   function void clear_msg();
      for (int i = 0; i < 8; i++) cv[i] = sha512_pkg::InitHash[i];
      for (int i = 0; i < 16; i++) buf_w[i] = '0;
      fill = 0;
      total = '0;
   endfunction

   function new();
      clear_msg();
      errors = 0;
      digests = 0;
      beats_in = 0;
   endfunction

   static function logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function void compress();
      logic [63:0] v [0:7];
      logic [63:0] w [0:15];
      logic [63:0] wr, t1, t2, a, b;
      for (int i = 0; i < 8; i++) v[i] = cv[i];
      for (int i = 0; i < 16; i++) w[i] = buf_w[i];
      for (int r = 0; r < 80; r++) begin
         if (r < 16) begin
            wr = w[r];
         end else begin
            a = w[(r - 2) & 15];
            b = w[(r - 15) & 15];
            wr = (ror(a, 19) ^ ror(a, 61) ^ (a >> 6)) + w[(r - 7) & 15]
               + (ror(b, 1) ^ ror(b, 8) ^ (b >> 7)) + w[r & 15];
            w[r & 15] = wr;
         end
         t1 = v[7] + (ror(v[4], 14) ^ ror(v[4], 18) ^ ror(v[4], 41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha512_pkg::RoundK[r] + wr;
         t2 = (ror(v[0], 28) ^ ror(v[0], 34) ^ ror(v[0], 39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         for (int i = 7; i > 0; i--) v[i] = v[i - 1];
         v[4] = v[4] + t1;
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) cv[i] = cv[i] + v[i];
   endfunction

   function void push_byte(logic [7:0] b);
      int sh;
      sh = 56 - 8 * (fill % 8);
      buf_w[fill / 8][sh +: 8] = b;
      fill++;
      if (fill >= 128) begin
         compress();
         fill = 0;
      end
   endfunction

   function void note_beat(logic [63:0] d, logic [3:0] cnt, logic eom);
      int n;
      beats_in++;
      n = (cnt > 8) ? 8 : cnt;
      for (int i = 0; i < n; i++) push_byte(d[56 - 8 * i +: 8]);
      total = total + n;
      if (!eom) return;
      push_byte(8'h80);
      if (fill > 112) while (fill != 0) push_byte(8'h00);
      while (fill < 112) push_byte(8'h00);
      buf_w[14] = total >> 61;
      buf_w[15] = total << 3;
      compress();
      for (int i = 0; i < 8; i++) begin
         want_word.push_back(cv[i]);
         want_idx.push_back(i[2:0]);
         want_last.push_back(i == 7);
      end
      clear_msg();
   endfunction

   function void check_beat(logic [63:0] d, logic [2:0] idx, logic last);
      if (want_word.size() == 0) begin
         $error("digest beat with nothing expected: word %h", d);
         errors++;
         return;
      end
      if (want_word[0] !== d) begin
         $error("digest_word expected %h actual %h", want_word[0], d);
         errors++;
      end
      if (want_idx[0] !== idx) begin
         $error("word_index expected %0d actual %0d", want_idx[0], idx);
         errors++;
      end
      if (want_last[0] !== last) begin
         $error("last_word expected %0d actual %0d", want_last[0], last);
         errors++;
      end
      if (last === 1'b1) digests++;
      void'(want_word.pop_front());
      void'(want_idx.pop_front());
      void'(want_last.pop_front());
   endfunction
endclass

module sha512_stream_hash_tb;
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_data_word = '0;
   logic [3:0]  req_byte_count = '0;
   logic        req_end_of_message = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   digest_board board = new();
   int unsigned cycles = 0;
   int unsigned burst_left = 0;
   int unsigned stall_mode = 0;
   bit          draining = 0;
   localparam int unsigned CycleLimit = 1500000;

   always #4 clock = ~clock;

   sha512_stream_hash uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_word(req_data_word), .req_byte_count(req_byte_count),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_digest_word(rsp_digest_word), .rsp_word_index(rsp_word_index),
      .rsp_last_word(rsp_last_word)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_valid && req_ready)
         board.note_beat(req_data_word, req_byte_count, req_end_of_message);
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat(rsp_digest_word, rsp_word_index, rsp_last_word);
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // receiver stall pattern, changes at the falling edge
   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (cycles % 7 < 2);
         default: rsp_ready <= ($urandom_range(0, 19) == 0);
      endcase
   end

   task automatic send_beat(input logic [63:0] d, input logic [3:0] cnt, input logic eom);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data_word <= d;
      req_byte_count <= cnt;
      req_end_of_message <= eom;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_message(input int unsigned nbytes);
      int unsigned left;
      int unsigned n;
      left = nbytes;
      while (left > 8) begin
         n = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 8;
         if ($urandom_range(0, 15) == 0) n = 15;
         if (n >= left) n = left - 1;
         send_beat(rand_word(), n[3:0], 1'b0);
         left -= (n > 8) ? 8 : n;
      end
      send_beat(rand_word(), left[3:0], 1'b1);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // directed: empty message, "abc", extremes, saturation, empty beats
      send_beat(64'h0, 4'd0, 1'b1);
      send_beat(64'h6162630000000000, 4'd3, 1'b1);
      send_beat(64'hffffffffffffffff, 4'd8, 1'b0);
      send_beat(64'h0, 4'd0, 1'b0);
      send_beat(64'hffffffffffffffff, 4'd15, 1'b0);
      send_beat(64'h0123456789abcdef, 4'd9, 1'b1);
      send_beat(64'h0, 4'd8, 1'b0);
      send_beat(64'haaaaaaaaaaaaaaaa, 4'd7, 1'b1);
      send_beat(64'h5555555555555555, 4'd1, 1'b1);
      // 111 and 112 bytes: length fits / needs extra block; 128 exactly
      for (int i = 0; i < 13; i++) send_beat(rand_word(), 4'd8, 1'b0);
      send_beat(rand_word(), 4'd7, 1'b1);
      send_message(112);
      send_message(128);
      // random messages, mostly short
      while (board.beats_in < 190) begin
         if ($urandom_range(0, 9) == 0) send_beat(rand_word(), 4'd0, 1'b0);
         else if ($urandom_range(0, 9) == 0) send_message($urandom_range(100, 260));
         else send_message($urandom_range(0, 40));
      end
      req_valid <= 1'b0;
      while (board.want_word.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("sent %0d beats, checked %0d digests", board.beats_in, board.digests);
      if (board.errors == 0 && board.want_word.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule
